// ===== sv/kvlt_pkg.sv =====
package kvlt_pkg;

    localparam int DEPTH      = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        OP_GET = 2'd0,
        OP_SET = 2'd1,
        OP_ADD = 2'd2,
        OP_DEL = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        t_op                   func;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value_in;
    } t_req;

    typedef struct packed {
        t_status               status;
        logic [VALUE_BITS-1:0] value_out;
        logic [CNT_W-1:0]      entry_count;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_APPEND,
        S_RESP
    } t_state;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        logic    rd_next;
        logic    inc_idx;
        logic    wr_set;
        logic    wr_shift;
        logic    append;
        logic    dec_cnt;
        logic    cap_value;
        logic    set_st;
        t_status st_code;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic at_end;
        logic match;
        logic full;
        logic last_shift;
    } t_sts;

endpackage

// ===== sv/kvlt_dp.sv =====
module kvlt_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kvlt_pkg::t_req i_req,
    input  kvlt_pkg::t_cmd i_cmd,
    output kvlt_pkg::t_sts o_sts,
    output kvlt_pkg::t_rsp o_rsp
);
    import kvlt_pkg::*;

    logic [KEY_BITS-1:0]   r_key_mem [DEPTH];
    logic [VALUE_BITS-1:0] r_val_mem [DEPTH];

    t_req                  r_req;
    logic [CNT_W-1:0]      r_idx;
    logic [CNT_W-1:0]      r_cnt;
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [VALUE_BITS-1:0] r_rd_val;
    t_status               r_status;
    logic [VALUE_BITS-1:0] r_vout;

    logic [CNT_W-1:0]      idx_inc;
    logic [IDX_W-1:0]      raddr;
    logic [IDX_W-1:0]      waddr;
    logic                  wr_key;
    logic                  wr_val;
    logic [KEY_BITS-1:0]   wkey;
    logic [VALUE_BITS-1:0] wval;

    assign idx_inc = r_idx + CNT_W'(1);
    assign raddr   = i_cmd.rd_next ? idx_inc[IDX_W-1:0] : r_idx[IDX_W-1:0];

    always_comb begin
        waddr  = r_idx[IDX_W-1:0];
        wkey   = r_rd_key;
        wval   = r_rd_val;
        wr_key = 1'b0;
        wr_val = 1'b0;
        if (i_cmd.append) begin
            waddr  = r_cnt[IDX_W-1:0];
            wkey   = r_req.key;
            wval   = r_req.value_in;
            wr_key = 1'b1;
            wr_val = 1'b1;
        end else if (i_cmd.wr_set) begin
            wval   = r_req.value_in;
            wr_val = 1'b1;
        end else if (i_cmd.wr_shift) begin
            wr_key = 1'b1;
            wr_val = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_key) begin
            r_key_mem[waddr] <= wkey;
        end
        if (wr_val) begin
            r_val_mem[waddr] <= wval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_key <= r_key_mem[raddr];
            r_rd_val <= r_val_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req;
            r_vout <= '0;
        end else if (i_cmd.cap_value) begin
            r_vout <= r_rd_val;
        end
        if (i_cmd.set_st) begin
            r_status <= i_cmd.st_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.inc_idx) begin
                r_idx <= idx_inc;
            end
            if (i_cmd.append) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_cmd.dec_cnt) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    assign o_sts.op         = r_req.func;
    assign o_sts.at_end     = (r_idx == r_cnt);
    assign o_sts.match      = (r_rd_key == r_req.key);
    assign o_sts.full       = (r_cnt == CNT_W'(DEPTH));
    assign o_sts.last_shift = (idx_inc >= r_cnt);

    assign o_rsp.status      = r_status;
    assign o_rsp.value_out   = r_vout;
    assign o_rsp.entry_count = r_cnt;

endmodule

// ===== sv/kvlt_ctrl.sv =====
module kvlt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  kvlt_pkg::t_sts i_sts,
    output kvlt_pkg::t_cmd o_cmd,
    output logic           o_busy,
    output logic           o_valid
);
    import kvlt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (i_sts.op == OP_ADD) begin
                    n_state = S_APPEND;
                end else if (i_sts.at_end) begin
                    n_state = (i_sts.op == OP_SET) ? S_APPEND : S_RESP;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (!i_sts.match) begin
                    n_state = S_READ;
                end else if (i_sts.op == OP_DEL) begin
                    n_state = S_SH_RD;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SH_RD: begin
                n_state = i_sts.last_shift ? S_RESP : S_SH_WR;
            end
            S_SH_WR: begin
                n_state = S_SH_RD;
            end
            S_APPEND: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.st_code = ST_OK;
        o_busy        = (r_state != S_IDLE);
        o_valid       = (r_state == S_RESP);
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
            end
            S_READ: begin
                if (i_sts.op != OP_ADD) begin
                    if (i_sts.at_end) begin
                        if (i_sts.op != OP_SET) begin
                            o_cmd.set_st  = 1'b1;
                            o_cmd.st_code = ST_NOT_FOUND;
                        end
                    end else begin
                        o_cmd.rd_en = 1'b1;
                    end
                end
            end
            S_CMP: begin
                if (!i_sts.match) begin
                    o_cmd.inc_idx = 1'b1;
                end else if (i_sts.op == OP_GET) begin
                    o_cmd.cap_value = 1'b1;
                    o_cmd.set_st    = 1'b1;
                end else if (i_sts.op == OP_SET) begin
                    o_cmd.wr_set = 1'b1;
                    o_cmd.set_st = 1'b1;
                end
            end
            S_SH_RD: begin
                if (i_sts.last_shift) begin
                    o_cmd.dec_cnt = 1'b1;
                    o_cmd.set_st  = 1'b1;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_next = 1'b1;
                end
            end
            S_SH_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.inc_idx  = 1'b1;
            end
            S_APPEND: begin
                o_cmd.set_st = 1'b1;
                if (i_sts.full) begin
                    o_cmd.st_code = ST_FULL;
                end else begin
                    o_cmd.append = 1'b1;
                end
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== sv/key_value_list_table.sv =====
// Key/value list table: up to 16 pairs kept densely in insertion order.
// Request beat: i_req (func, key, value_in) is taken on a rising edge with
// start high and busy low. busy stays high until the result has gone out.
// Result beat: o_rsp (status, value_out, entry_count) is shown for exactly
// one cycle with o_valid high; the receiver cannot stall, so it must take
// the beat in that cycle.
// Search: the entries are read one at a time from a single read port
// memory, through a read state and then a compare state for each. A get
// or set stops at the first matching entry, and a miss reads every entry.
// A set miss then appends in a further state; an add appends with no
// search. A delete shifts each later entry down one place, reading
// and then writing each in turn. The longest request is a set of a new
// key on a full table. The next request may be taken in the cycle after
// the result beat.
// Reset clears the entry count and returns the sequencer to idle; stored
// keys and values are left as they are and are never read above the count.
module key_value_list_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  kvlt_pkg::t_req i_req,
    output logic           busy,
    output logic           o_valid,
    output kvlt_pkg::t_rsp o_rsp
);
    import kvlt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    kvlt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    kvlt_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== verif/key_value_list_table_tb.sv =====
module key_value_list_table_tb;
    import kvlt_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_GAP = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    t_req req = '0;
    logic busy;
    logic rsp_valid;
    t_rsp rsp;

    logic [KEY_BITS-1:0] tbl_key [DEPTH];
    logic [VALUE_BITS-1:0] tbl_val [DEPTH];
    int tbl_count = 0;
    int peak_count = 0;

    t_rsp reply_q[$];
    logic [KEY_BITS-1:0] key_pool [8];
    bit gaps_on = 1'b1;

    int cycle = 0;
    int errors = 0;
    int n_replies = 0;
    int n_ok = 0;
    int n_missing = 0;
    int n_full = 0;

    key_value_list_table dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .start   (start),
        .i_req   (req),
        .busy    (busy),
        .o_valid (rsp_valid),
        .o_rsp   (rsp)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (cycle >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d replies awaited",
                     cycle, reply_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 20)
            $display("cycle %0d, reply %0d: %s", cycle, n_replies, msg);
    endtask

    function automatic t_rsp kv_reply(input t_req r);
        t_rsp o;
        int pos;
        pos = tbl_count;
        for (int i = 0; i < tbl_count; i++) begin
            if (pos == tbl_count && tbl_key[i] == r.key)
                pos = i;
        end
        o.status = ST_OK;
        o.value_out = '0;
        case (r.func)
            OP_GET: begin
                if (pos < tbl_count)
                    o.value_out = tbl_val[pos];
                else
                    o.status = ST_NOT_FOUND;
            end
            OP_SET, OP_ADD: begin
                if (r.func == OP_SET && pos < tbl_count) begin
                    tbl_val[pos] = r.value_in;
                end else if (tbl_count >= DEPTH) begin
                    o.status = ST_FULL;
                end else begin
                    tbl_key[tbl_count] = r.key;
                    tbl_val[tbl_count] = r.value_in;
                    tbl_count++;
                end
            end
            default: begin
                if (pos >= tbl_count) begin
                    o.status = ST_NOT_FOUND;
                end else begin
                    for (int i = pos; i + 1 < tbl_count; i++) begin
                        tbl_key[i] = tbl_key[i + 1];
                        tbl_val[i] = tbl_val[i + 1];
                    end
                    tbl_count--;
                end
            end
        endcase
        o.entry_count = tbl_count[CNT_W-1:0];
        if (tbl_count > peak_count)
            peak_count = tbl_count;
        return o;
    endfunction

    // Hold start until the beat is taken, then maybe drop it for a gap.
    task automatic send_item(input t_op op, input logic [KEY_BITS-1:0] k,
                             input logic [VALUE_BITS-1:0] v);
        t_req r;
        r.func = op;
        r.key = k;
        r.value_in = v;
        start <= 1'b1;
        req <= r;
        do @(posedge clk); while (busy !== 1'b0);
        reply_q.push_back(kv_reply(r));
        if (gaps_on && $urandom_range(99) < 30) begin
            start <= 1'b0;
            req <= {2'($urandom_range(3)), $urandom, $urandom};
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
        end
    endtask

    always @(posedge clk) begin : check_replies
        t_rsp exp;
        if (rst_n && $isunknown(rsp_valid)) begin
            report_mismatch("result strobe unknown");
        end else if (rst_n && rsp_valid) begin
            if (reply_q.size() == 0) begin
                report_mismatch("result beat with nothing awaited");
            end else begin
                exp = reply_q.pop_front();
                if (rsp.status !== exp.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              rsp.status, exp.status));
                if (rsp.value_out !== exp.value_out)
                    report_mismatch($sformatf("value_out %h, expected %h",
                                              rsp.value_out, exp.value_out));
                if (rsp.entry_count !== exp.entry_count)
                    report_mismatch($sformatf("entry_count %0d, expected %0d",
                                              rsp.entry_count, exp.entry_count));
                case (exp.status)
                    ST_OK:        n_ok++;
                    ST_NOT_FOUND: n_missing++;
                    default:      n_full++;
                endcase
            end
            n_replies++;
        end
    end

    task automatic test_empty_table;
        send_item(OP_GET, $urandom, $urandom);
        send_item(OP_DEL, 32'h0, $urandom);
        send_item(OP_GET, 32'h0, $urandom);
    endtask

    task automatic test_basic_ops;
        send_item(OP_ADD, 32'h0, 32'h0);
        send_item(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_GET, 32'hFFFF_FFFF, $urandom);
        send_item(OP_SET, 32'h0, 32'h5A5A_A5A5);
        send_item(OP_ADD, 32'h0, 32'h1234_5678);
        send_item(OP_GET, 32'h0, $urandom);
        send_item(OP_DEL, 32'h0, $urandom);
        send_item(OP_GET, 32'h0, $urandom);
        send_item(OP_GET, 32'h0000_0001, $urandom);
        send_item(OP_DEL, 32'hFFFF_FFFF, $urandom);
        send_item(OP_DEL, 32'h0, $urandom);
    endtask

    task automatic test_full_table;
        while (tbl_count < DEPTH)
            send_item(OP_ADD, 32'h100 + tbl_count, $urandom);
        send_item(OP_ADD, 32'h100, $urandom);
        send_item(OP_SET, 32'hDEAD_0000, $urandom);
        send_item(OP_SET, 32'h100 + DEPTH - 1, $urandom);
        send_item(OP_DEL, 32'h100, $urandom);
        send_item(OP_GET, 32'h100 + DEPTH - 1, $urandom);
        send_item(OP_DEL, 32'h100 + DEPTH - 1, $urandom);
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key;
        int c;
        c = $urandom_range(99);
        if (c < 50 && tbl_count > 0)
            return tbl_key[$urandom_range(tbl_count - 1)];
        else if (c < 85)
            return key_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    task automatic test_random_traffic(input int n, input int grow_pct, input int del_pct);
        int r;
        t_op op;
        for (int i = 0; i < 8; i++)
            key_pool[i] = $urandom;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < del_pct)
                op = OP_DEL;
            else if (r < del_pct + grow_pct)
                op = $urandom_range(1) ? OP_SET : OP_ADD;
            else
                op = OP_GET;
            send_item(op, pick_key(), $urandom);
        end
    endtask

    // Drop start at the next edge, then wait for every awaited result and drain.
    task automatic finish_run;
        @(posedge clk);
        start <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_basic_ops();
        test_full_table();
        test_random_traffic(360, 60, 10);
        test_random_traffic(360, 15, 55);
        gaps_on = 1'b0;
        test_random_traffic(360, 35, 30);
        gaps_on = 1'b1;
        test_random_traffic(370, 50, 20);
        finish_run();
        $display("Checked %0d results: %0d ok, %0d key not found, %0d table full",
                 n_replies, n_ok, n_missing, n_full);
        $display("Table filled to %0d of %0d entries; %0d mismatches",
                 peak_count, DEPTH, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/kvlt_pkg.sv
sv/kvlt_dp.sv
sv/kvlt_ctrl.sv
sv/key_value_list_table.sv
verif/key_value_list_table_tb.sv
